// ===== sv/assert_macros.svh =====
// assertion macros shared by the transmitter rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== sv/mnt_pkg.sv =====
// types and constants for the manchester nibble transmitter
// no dependencies; used by mnt_step and the top level
package mnt_pkg;

  localparam int unsigned HalfW = 16;
  localparam int unsigned TickW = HalfW + 1;
  localparam int unsigned IdxW = 4;
  localparam int unsigned NibW = 4;

  localparam logic [HalfW-1:0] ResetHalfTicks = 16'd150;
  localparam logic [IdxW-1:0] SyncLevels = 4'd4;
  localparam logic [IdxW-1:0] FrameHalves = 4'd10;
  localparam logic [IdxW-1:0] StartHalves = 4'd2;
  localparam logic [IdxW-1:0] FirstDataEnd = 4'd3;

  typedef enum logic [2:0] {
    ModeSync  = 3'b001,
    ModeFrame = 3'b010,
    ModeIdle  = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [TickW-1:0]  tick;
    logic [IdxW-1:0]   half;
    logic [NibW-1:0]   data;
    logic              line;
  } state_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic request_taken;
  } result_t;

endpackage

// ===== sv/mnt_step.sv =====
// next-state and per-tick result logic of the manchester transmitter
// depends on mnt_pkg
module mnt_step (
  input  mnt_pkg::state_t              state_i,
  input  logic                         send_request_i,
  input  logic [mnt_pkg::NibW-1:0]     nibble_i,
  input  logic [mnt_pkg::HalfW-1:0]    half_bit_ticks_i,
  output mnt_pkg::state_t              state_o,
  output mnt_pkg::result_t             result_o
);

  mnt_pkg::state_t           st;
  logic                      taken;
  logic [mnt_pkg::TickW-1:0] half_len;
  logic [mnt_pkg::TickW-1:0] dur;
  logic [mnt_pkg::TickW-1:0] tick_inc;
  logic [mnt_pkg::IdxW-1:0]  half_inc;
  logic                      level;
  logic                      active;

  assign half_len = (half_bit_ticks_i == '0) ? mnt_pkg::TickW'(1)
                                             : {1'b0, half_bit_ticks_i};

  always_comb begin
    st    = state_i;
    taken = 1'b0;
    case (state_i.mode)
      mnt_pkg::ModeSync, mnt_pkg::ModeFrame: taken = 1'b0;
      default: taken = send_request_i;
    endcase
    if (taken) begin
      st.mode = mnt_pkg::ModeFrame;
      st.tick = '0;
      st.half = '0;
      st.data = nibble_i;
    end
  end

  always_comb begin
    active   = 1'b0;
    level    = state_i.line;
    dur      = half_len;
    case (st.mode)
      mnt_pkg::ModeSync: begin
        active = 1'b1;
        level  = ~st.half[0];
        dur    = {half_len[mnt_pkg::TickW-2:0], 1'b0};
      end
      mnt_pkg::ModeFrame: begin
        active = 1'b1;
        dur    = half_len;
        if (st.half < mnt_pkg::StartHalves) begin
          level = st.half[0];
        end else begin
          level = st.data[mnt_pkg::NibW-1] ? st.half[0] : ~st.half[0];
        end
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  assign tick_inc = st.tick + mnt_pkg::TickW'(1);
  assign half_inc = st.half + mnt_pkg::IdxW'(1);

  always_comb begin
    state_o = st;
    if (active) begin
      state_o.line = level;
      state_o.tick = tick_inc;
      if (tick_inc >= dur) begin
        state_o.tick = '0;
        state_o.half = half_inc;
        if (st.mode == mnt_pkg::ModeFrame && st.half >= mnt_pkg::FirstDataEnd
            && st.half[0]) begin
          state_o.data = {st.data[mnt_pkg::NibW-2:0], 1'b0};
        end
        if ((st.mode == mnt_pkg::ModeSync && half_inc >= mnt_pkg::SyncLevels) ||
            (st.mode == mnt_pkg::ModeFrame && half_inc >= mnt_pkg::FrameHalves)) begin
          state_o.mode = mnt_pkg::ModeIdle;
          state_o.half = '0;
        end
      end
    end
  end

  assign result_o.line_level    = level;
  assign result_o.busy_res      = active;
  assign result_o.request_taken = taken;

endmodule

// ===== sv/manchester_nibble_transmitter_unit.sv =====
// top level of the manchester nibble transmitter: state, config and result registers
// depends on mnt_pkg, mnt_step and assert_macros.svh
//
//   channel | direction | signals
//   in      | input     | in_valid_i, in_ready_o, send_request_i, nibble_i
//   out     | output    | out_valid_o, out_ready_i, line_level_o, busy_res_o, request_taken_o
//   cfg     | input     | cfg_we_i, cfg_wdata_i (half_bit_ticks)
//
// one tick per cycle while in_fire is high; its result is in the result register next cycle
// the rate is set by the combinational state update in mnt_step
// an input beat is taken whenever the result register is empty or being drained
// reset starts the sync preamble with the line low and half_bit_ticks at 150
`include "assert_macros.svh"

module manchester_nibble_transmitter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      send_request_i,
  input  logic [mnt_pkg::NibW-1:0]  nibble_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      line_level_o,
  output logic                      busy_res_o,
  output logic                      request_taken_o,
  input  logic                      cfg_we_i,
  input  logic [mnt_pkg::HalfW-1:0] cfg_wdata_i
);

  mnt_pkg::state_t           state_q, state_d;
  mnt_pkg::result_t          result_q, result_d;
  logic [mnt_pkg::HalfW-1:0] half_ticks_q;
  logic                      out_valid_q;
  logic                      in_fire;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  mnt_step u_step (
    .state_i          (state_q),
    .send_request_i   (send_request_i),
    .nibble_i         (nibble_i),
    .half_bit_ticks_i (half_ticks_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= mnt_pkg::ModeSync;
      state_q.tick <= '0;
      state_q.half <= '0;
      state_q.data <= '0;
      state_q.line <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_ticks_q <= mnt_pkg::ResetHalfTicks;
    end else if (cfg_we_i) begin
      half_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = result_q.line_level;
  assign busy_res_o      = result_q.busy_res;
  assign request_taken_o = result_q.request_taken;

  `ASSERT_IMPL(a_taken_busy, clk_i, rst_ni, out_valid_o && request_taken_o, busy_res_o, "accepted request without busy")
  `ASSERT_IMPL(a_fire_fills, clk_i, rst_ni, in_fire, ##1 out_valid_o, "input beat lost its result")
  `ASSERT_IMPL(a_idle_holds, clk_i, rst_ni, state_q.mode == mnt_pkg::ModeIdle && !in_fire, ##1 $stable(state_q.line), "line moved while idle")
  `ASSERT_IMPL(a_frame_idx, clk_i, rst_ni, state_q.mode == mnt_pkg::ModeFrame, state_q.half < mnt_pkg::FrameHalves, "frame half index out of range")
  `ASSERT_CLK(a_idle_line, clk_i, rst_ni, !(out_valid_o && !busy_res_o && request_taken_o), "request taken on idle result")

endmodule
